/* hw/rtl/prbp_pkg.sv */
// shared types, sizes and codes for the pipe ring buffer pool
package prbp_pkg;

  // pool geometry
  localparam int unsigned NUM_PIPES = 8;
  localparam int unsigned BUF_BYTES = 256;

  // derived widths
  localparam int unsigned PIPE_W = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
  localparam int unsigned PTR_W  = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;
  localparam int unsigned CNT_W  = $clog2(BUF_BYTES + 1);
  localparam int unsigned OPEN_W = $clog2(NUM_PIPES + 1);
  localparam int unsigned MEM_DEPTH = NUM_PIPES * BUF_BYTES;
  localparam int unsigned ADDR_W = $clog2(MEM_DEPTH);

  // word kinds
  typedef enum logic [1:0] {
    KIND_CREATE = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_READ   = 2'd2
  } kind_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_BAD    = 3'd1,
    ST_FULL   = 3'd2,
    ST_EMPTY  = 3'd3,
    ST_NOFREE = 3'd4
  } status_e;

  // input word
  typedef struct packed {
    kind_e       kind;
    logic [3:0]  pipe_id;
    logic [7:0]  data_in;
    logic        end_of_call;
  } in_t;

  // result word
  typedef struct packed {
    status_e     status;
    logic [7:0]  data_out;
    logic [2:0]  new_pipe_id;
    logic [3:0]  open_pipes;
    logic [8:0]  fill_level;
    logic [15:0] bytes_done;
  } out_t;

  // result fields from the pipe controller, data byte comes from the ram
  typedef struct packed {
    status_e     status;
    logic [2:0]  new_pipe_id;
    logic [3:0]  open_pipes;
    logic [8:0]  fill_level;
    logic [15:0] bytes_done;
    logic        rd_ok;
  } res_t;

  // byte store access
  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic [7:0]        wdata;
  } mem_req_t;

endpackage

/* hw/rtl/prbp_ram.sv */
// generic ram with one write port and one registered read port
module prbp_ram #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/prbp_ctrl.sv */
// pipe table, call counter and per-word decision logic
module prbp_ctrl import prbp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_t      in_data_i,
  output res_t     res_o,
  output mem_req_t mem_req_o
);

  logic             open_q [NUM_PIPES];
  logic             open_d [NUM_PIPES];
  logic [PTR_W-1:0] head_q [NUM_PIPES];
  logic [PTR_W-1:0] head_d [NUM_PIPES];
  logic [PTR_W-1:0] tail_q [NUM_PIPES];
  logic [PTR_W-1:0] tail_d [NUM_PIPES];
  logic [CNT_W-1:0] cnt_q  [NUM_PIPES];
  logic [CNT_W-1:0] cnt_d  [NUM_PIPES];
  logic [15:0]      call_q;
  logic [15:0]      call_d;

  logic              pid_ok;
  logic [PIPE_W-1:0] idx;
  logic              sel_open;
  logic              free_found;
  logic [PIPE_W-1:0] free_idx;
  logic [OPEN_W-1:0] open_cnt;
  logic [PTR_W-1:0]  sel_head;
  logic [PTR_W-1:0]  sel_tail;
  logic [CNT_W-1:0]  sel_cnt;
  logic [PTR_W-1:0]  head_nxt;
  logic [PTR_W-1:0]  tail_nxt;
  logic [ADDR_W-1:0] base;
  logic              moved;
  logic              created;
  logic [15:0]       call_inc;

  // addressed pipe lookup
  always_comb begin
    pid_ok   = ({1'b0, in_data_i.pipe_id} < 5'(NUM_PIPES));
    idx      = PIPE_W'(in_data_i.pipe_id);
    sel_open = 1'b0;
    sel_head = '0;
    sel_tail = '0;
    sel_cnt  = '0;
    if (pid_ok) begin
      sel_open = open_q[idx];
      sel_head = head_q[idx];
      sel_tail = tail_q[idx];
      sel_cnt  = cnt_q[idx];
    end
    head_nxt = (sel_head == PTR_W'(BUF_BYTES - 1)) ? '0 : sel_head + 1'b1;
    tail_nxt = (sel_tail == PTR_W'(BUF_BYTES - 1)) ? '0 : sel_tail + 1'b1;
    base     = ADDR_W'(idx) * ADDR_W'(BUF_BYTES);
  end

  // lowest free pipe and open count
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    open_cnt   = '0;
    for (int i = NUM_PIPES - 1; i >= 0; i--) begin
      if (!open_q[i]) begin
        free_found = 1'b1;
        free_idx   = PIPE_W'(i);
      end
      open_cnt = open_cnt + OPEN_W'(open_q[i]);
    end
  end

  // decision and next state
  always_comb begin
    open_d  = open_q;
    head_d  = head_q;
    tail_d  = tail_q;
    cnt_d   = cnt_q;
    moved   = 1'b0;
    created = 1'b0;

    res_o             = '0;
    res_o.status      = ST_BAD;
    mem_req_o         = '0;
    mem_req_o.waddr   = base + ADDR_W'(sel_tail);
    mem_req_o.raddr   = base + ADDR_W'(sel_head);
    mem_req_o.wdata   = in_data_i.data_in;

    case (in_data_i.kind)
      KIND_CREATE: begin
        res_o.status = ST_NOFREE;
        if (free_found) begin
          created           = 1'b1;
          open_d[free_idx]  = 1'b1;
          head_d[free_idx]  = '0;
          tail_d[free_idx]  = '0;
          cnt_d[free_idx]   = '0;
          res_o.status      = ST_OK;
          res_o.new_pipe_id = 3'(free_idx);
        end
      end
      KIND_WRITE: begin
        if (sel_open) begin
          res_o.fill_level = 9'(sel_cnt);
          if (sel_cnt >= CNT_W'(BUF_BYTES)) begin
            res_o.status = ST_FULL;
          end else begin
            moved            = 1'b1;
            mem_req_o.we     = accept_i;
            tail_d[idx]      = tail_nxt;
            cnt_d[idx]       = sel_cnt + 1'b1;
            res_o.status     = ST_OK;
            res_o.fill_level = 9'(sel_cnt + 1'b1);
          end
        end
      end
      KIND_READ: begin
        if (sel_open) begin
          res_o.fill_level = 9'(sel_cnt);
          if (sel_cnt == '0) begin
            res_o.status = ST_EMPTY;
          end else begin
            moved            = 1'b1;
            mem_req_o.re     = accept_i;
            res_o.rd_ok      = 1'b1;
            head_d[idx]      = head_nxt;
            cnt_d[idx]       = sel_cnt - 1'b1;
            res_o.status     = ST_OK;
            res_o.fill_level = 9'(sel_cnt - 1'b1);
          end
        end
      end
      default: begin
        res_o.status = ST_BAD;
      end
    endcase

    // per-call byte counter, saturating, cleared after the last word of a call
    call_inc         = (moved && call_q != 16'hffff) ? call_q + 16'd1 : call_q;
    call_d           = in_data_i.end_of_call ? '0 : call_inc;
    res_o.bytes_done = call_inc;
    res_o.open_pipes = 4'(open_cnt + OPEN_W'(created));
  end

  // pipe table and counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PIPES; i++) begin
        open_q[i] <= 1'b0;
        head_q[i] <= '0;
        tail_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
      call_q <= '0;
    end else if (accept_i) begin
      open_q <= open_d;
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
      call_q <= call_d;
    end
  end

endmodule

/* hw/rtl/pipe_ring_buffer_pool.sv */
// top level of the pipe ring buffer pool: decision logic, byte store, result register
//
// Pool of NUM_PIPES byte pipes, each a ring of BUF_BYTES bytes. A create word
// claims the lowest free pipe, a write word appends a byte, a read word pops
// the oldest byte; every word gives exactly one result word. One word is taken
// every cycle and its result is shown in the next cycle; a stalled result holds
// back the input only while it waits. Pipe pointers, counts and open flags live
// in flip-flops and are cleared at once by reset; the byte store is a ram with
// one write and one registered read per cycle, needs no clearing pass, and its read
// register keeps the popped byte in step with the registered result.
module pipe_ring_buffer_pool import prbp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  logic     accept;
  res_t     res;
  res_t     res_q;
  mem_req_t mem_req;
  logic [7:0] rdata;
  logic     out_valid_q;

  // handshake
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // pipe table and decision
  prbp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_data_i (in_data_i),
    .res_o     (res),
    .mem_req_o (mem_req)
  );

  // byte store
  prbp_ram #(
    .DEPTH (MEM_DEPTH),
    .WIDTH (8)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata)
  );

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  // output word
  always_comb begin
    out_data_o             = '0;
    out_data_o.status      = res_q.status;
    out_data_o.data_out    = res_q.rd_ok ? rdata : 8'd0;
    out_data_o.new_pipe_id = res_q.new_pipe_id;
    out_data_o.open_pipes  = res_q.open_pipes;
    out_data_o.fill_level  = res_q.fill_level;
    out_data_o.bytes_done  = res_q.bytes_done;
  end

  assign out_valid_o = out_valid_q;

  // a popped byte only comes with an ok status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.data_out != 8'd0 |-> out_data_o.status == ST_OK)
    else $error("data byte without ok status");

  // no free pipe only when the pool is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_NOFREE |->
      out_data_o.open_pipes == 4'(NUM_PIPES))
    else $error("no free pipe reported with free pipes left");

  // fill level never exceeds the ring size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.fill_level <= 9'(BUF_BYTES))
    else $error("fill level above ring size");

  // every accepted word shows a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted word gave no result");

  // a bad pipe reports an empty fill level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_BAD |-> out_data_o.fill_level == 9'd0)
    else $error("bad pipe with nonzero fill level");

endmodule

/* dv/pipe_ring_buffer_pool_tb.sv */
// self-checking testbench for the pipe ring buffer pool
module pipe_ring_buffer_pool_tb;
  import prbp_pkg::*;

  // kind code that the block does not decode
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  pipe_ring_buffer_pool dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // shadow copy of the pool state
  logic                 slot_used [NUM_PIPES];
  logic [PTR_W-1:0]     rd_ptr    [NUM_PIPES];
  logic [PTR_W-1:0]     wr_ptr    [NUM_PIPES];
  logic [CNT_W-1:0]     level     [NUM_PIPES];
  logic [7:0]           byte_copy [MEM_DEPTH];
  logic [15:0]          call_bytes;

  out_t        pending_results [$];
  int unsigned fail_count = 0;

  // sender burst state
  int unsigned burst_left = 0;
  bit          sending = 1'b0;

  // receiver stall state
  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;
  bit          hold_level = 1'b1;

  initial begin
    for (int i = 0; i < NUM_PIPES; i++) begin
      slot_used[i] = 1'b0;
      rd_ptr[i] = '0;
      wr_ptr[i] = '0;
      level[i] = '0;
    end
    call_bytes = '0;
  end

  // count one moved byte, saturating
  function automatic void bump_call_bytes();
    if (call_bytes != 16'hffff) call_bytes = call_bytes + 16'd1;
  endfunction

  // expected result of one word, advances the shadow state
  function automatic out_t predict_pool_result(input in_t w);
    out_t        r;
    int unsigned n;
    int unsigned id;
    int unsigned addr;
    r = '0;
    r.status = ST_BAD;
    id = w.pipe_id;
    if (w.kind == KIND_CREATE) begin
      r.status = ST_NOFREE;
      for (int i = 0; i < NUM_PIPES; i++) begin
        if (!slot_used[i] && r.status == ST_NOFREE) begin
          slot_used[i] = 1'b1;
          rd_ptr[i] = '0;
          wr_ptr[i] = '0;
          level[i] = '0;
          r.status = ST_OK;
          r.new_pipe_id = 3'(i);
        end
      end
    end else if ((w.kind == KIND_WRITE || w.kind == KIND_READ) && id < NUM_PIPES
                 && slot_used[id]) begin
      if (w.kind == KIND_WRITE) begin
        if (level[id] >= BUF_BYTES) begin
          r.status = ST_FULL;
        end else begin
          addr = id * BUF_BYTES + wr_ptr[id];
          byte_copy[addr] = w.data_in;
          wr_ptr[id] = wr_ptr[id] + 1'b1;
          level[id] = level[id] + 1'b1;
          bump_call_bytes();
          r.status = ST_OK;
        end
      end else begin
        if (level[id] == 0) begin
          r.status = ST_EMPTY;
        end else begin
          addr = id * BUF_BYTES + rd_ptr[id];
          r.data_out = byte_copy[addr];
          rd_ptr[id] = rd_ptr[id] + 1'b1;
          level[id] = level[id] - 1'b1;
          bump_call_bytes();
          r.status = ST_OK;
        end
      end
      r.fill_level = 9'(level[id]);
    end
    n = 0;
    for (int i = 0; i < NUM_PIPES; i++) if (slot_used[i]) n++;
    r.open_pipes = 4'(n);
    r.bytes_done = call_bytes;
    if (w.end_of_call) call_bytes = '0;
    return r;
  endfunction

  function automatic in_t make_word(input logic [1:0] k, input logic [3:0] id,
                                    input logic [7:0] data, input logic last);
    in_t w;
    w.kind = kind_e'(k);
    w.pipe_id = id;
    w.data_in = data;
    w.end_of_call = last;
    return w;
  endfunction

  // one line per mismatch, all counted
  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    fail_count++;
    $display("mismatch %s: got %0h expected %0h", what, got, want);
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected result word", 16'(got.status), 16'h0);
    end else begin
      want = pending_results.pop_front();
      if (got.status !== want.status)
        report_mismatch("status", 16'(got.status), 16'(want.status));
      if (got.data_out !== want.data_out)
        report_mismatch("data_out", 16'(got.data_out), 16'(want.data_out));
      if (got.new_pipe_id !== want.new_pipe_id)
        report_mismatch("new_pipe_id", 16'(got.new_pipe_id), 16'(want.new_pipe_id));
      if (got.open_pipes !== want.open_pipes)
        report_mismatch("open_pipes", 16'(got.open_pipes), 16'(want.open_pipes));
      if (got.fill_level !== want.fill_level)
        report_mismatch("fill_level", 16'(got.fill_level), 16'(want.fill_level));
      if (got.bytes_done !== want.bytes_done)
        report_mismatch("bytes_done", got.bytes_done, want.bytes_done);
    end
  endtask

  // result checker and receiver stall pattern
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) check_result(out_data);
    if (mode_left == 0) begin
      mode_left = $urandom_range(16, 200);
      stall_mode = $urandom_range(0, 9);
    end else begin
      mode_left--;
    end
    if (stall_mode < 4) begin
      out_ready <= 1'b1;
    end else if (stall_mode < 8) begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end else begin
      // long stalls with short open windows
      if (hold_left == 0) begin
        hold_level = ~hold_level;
        hold_left = hold_level ? $urandom_range(1, 4) : $urandom_range(1, 12);
      end else begin
        hold_left--;
      end
      out_ready <= hold_level;
    end
  end

  // send one word in bursts with random gaps
  task automatic send_word(input in_t w);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (sending) begin
        in_valid <= 1'b0;
        sending = 1'b0;
        if (gap == 0) gap = 1;
      end
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    in_data <= w;
    sending = 1'b1;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    pending_results.push_back(predict_pool_result(w));
    burst_left--;
  endtask

  // stop sending and wait for every result to come back
  task automatic wait_results_done();
    if (sending) begin
      in_valid <= 1'b0;
      sending = 1'b0;
    end
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // accesses before any pipe is open, unused kind, out of range id
  task automatic test_unopened_access();
    send_word(make_word(KIND_WRITE, 4'd0, 8'h00, 1'b0));
    send_word(make_word(KIND_READ, 4'd0, 8'hff, 1'b1));
    send_word(make_word(KIND_UNUSED, 4'd15, 8'hff, 1'b1));
    send_word(make_word(KIND_WRITE, 4'd15, 8'hff, 1'b0));
    wait_results_done();
  endtask

  // claim every pipe, touch one still closed, then run out
  task automatic test_create_pipes();
    send_word(make_word(KIND_CREATE, 4'd0, 8'h00, 1'b0));
    send_word(make_word(KIND_CREATE, 4'd15, 8'hff, 1'b0));
    send_word(make_word(KIND_WRITE, 4'd2, 8'ha5, 1'b0));
    for (int i = 0; i < NUM_PIPES - 2; i++)
      send_word(make_word(KIND_CREATE, 4'(i), 8'($urandom), 1'b0));
    send_word(make_word(KIND_CREATE, 4'd0, 8'h00, 1'b1));
    wait_results_done();
  endtask

  // byte extremes, order, empty pipe, bad ids, end of call on odd kinds
  task automatic test_basic_write_read();
    send_word(make_word(KIND_WRITE, 4'd0, 8'h00, 1'b0));
    send_word(make_word(KIND_WRITE, 4'd0, 8'hff, 1'b0));
    send_word(make_word(KIND_WRITE, 4'd3, 8'h5a, 1'b1));
    send_word(make_word(KIND_READ, 4'd0, 8'h00, 1'b0));
    send_word(make_word(KIND_READ, 4'd0, 8'h00, 1'b1));
    send_word(make_word(KIND_READ, 4'd0, 8'h00, 1'b0));
    send_word(make_word(KIND_WRITE, 4'd15, 8'h81, 1'b0));
    send_word(make_word(KIND_READ, 4'd3, 8'h00, 1'b0));
    send_word(make_word(KIND_READ, 4'd9, 8'h00, 1'b0));
    send_word(make_word(KIND_UNUSED, 4'd3, 8'h7e, 1'b1));
    send_word(make_word(KIND_READ, 4'd3, 8'h00, 1'b0));
    wait_results_done();
  endtask

  // fill one pipe to the brim, overflow it, drain past empty
  task automatic test_full_pipe();
    for (int i = 0; i < BUF_BYTES; i++)
      send_word(make_word(KIND_WRITE, 4'(NUM_PIPES - 1), 8'($urandom), i == BUF_BYTES - 1));
    send_word(make_word(KIND_WRITE, 4'(NUM_PIPES - 1), 8'hff, 1'b0));
    send_word(make_word(KIND_WRITE, 4'(NUM_PIPES - 1), 8'h00, 1'b1));
    for (int i = 0; i <= BUF_BYTES; i++)
      send_word(make_word(KIND_READ, 4'(NUM_PIPES - 1), 8'($urandom), i == BUF_BYTES));
    wait_results_done();
  endtask

  // one long call that keeps the byte counter climbing, then a clear
  task automatic test_long_call();
    for (int i = 0; i < 200; i++)
      send_word(make_word((i % 2 == 0) ? KIND_WRITE : KIND_READ, 4'd1,
                          8'($urandom), 1'b0));
    send_word(make_word(KIND_WRITE, 4'd1, 8'($urandom), 1'b1));
    send_word(make_word(KIND_READ, 4'd1, 8'($urandom), 1'b0));
    send_word(make_word(KIND_READ, 4'd1, 8'($urandom), 1'b1));
    wait_results_done();
  endtask

  // random calls on open pipes mixed with bad and unused words
  task automatic test_random_traffic();
    int unsigned good;
    int unsigned run;
    int unsigned pid;
    int unsigned sel;
    int unsigned style;
    logic [1:0]  k;
    good = 0;
    while (good < 500) begin
      sel = $urandom_range(0, 99);
      if (sel < 85) begin
        pid = $urandom_range(0, NUM_PIPES - 1);
        style = $urandom_range(0, 2);
        run = $urandom_range(1, 24);
        for (int j = 0; j < run; j++) begin
          if (style == 0) k = KIND_WRITE;
          else if (style == 1) k = KIND_READ;
          else k = $urandom_range(0, 1) ? KIND_WRITE : KIND_READ;
          send_word(make_word(k, 4'(pid), 8'($urandom),
                              (j == run - 1) || ($urandom_range(0, 15) == 0)));
        end
        good += run;
      end else if (sel < 95) begin
        k = $urandom_range(0, 1) ? KIND_WRITE : KIND_READ;
        send_word(make_word(k, 4'($urandom_range(NUM_PIPES, 15)), 8'($urandom),
                            1'($urandom)));
      end else begin
        send_word(make_word(2'($urandom), 4'($urandom), 8'($urandom), 1'($urandom)));
      end
    end
    wait_results_done();
  endtask

  // test sequence
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_unopened_access();
    test_create_pipes();
    test_basic_write_read();
    test_full_pipe();
    test_long_call();
    test_random_traffic();
    if (pending_results.size() != 0)
      report_mismatch("results never returned", 16'(pending_results.size()), 16'h0);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // run time limit
  initial begin
    #25000000;
    $display("FAIL");
    $finish;
  end

endmodule
